// ----- hw/rtl/trmcov_pkg.sv -----
// package for the trajectory mean and x/y covariance core
// types, codes and fixed field widths shared by trmcov_ctrl, trmcov_dp and the top level
`timescale 1ns / 1ps
package trmcov_pkg;

	localparam int unsigned MAX_SAMPLES_DEF = 1024;
	localparam int unsigned MAX_STEPS_DEF   = 64;

	localparam int POS_W      = 24;
	localparam int HEAD_W     = 16;
	localparam int VAR_W      = 48;
	localparam int COV_W      = 49;
	localparam int TS_W       = 6;
	localparam int CFG_DATA_W = 11;
	localparam int STEPC_W    = 7;

	localparam logic [CFG_DATA_W-1:0] SAMPLE_COUNT_RST = 11'd1024;
	localparam logic [STEPC_W-1:0]    STEP_COUNT_RST   = 7'd64;

	typedef enum logic {
		REG_SAMPLE_COUNT = 1'b0,
		REG_STEP_COUNT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RDSUM,
		ST_DMX,
		ST_DMY,
		ST_DMH,
		ST_ACC,
		ST_DRAIN,
		ST_DVXX,
		ST_DVYY,
		ST_DCXY,
		ST_FIX,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		DIV_MX,
		DIV_MY,
		DIV_MH,
		DIV_VXX,
		DIV_VYY,
		DIV_CXY
	} div_sel_t;

	typedef struct packed {
		logic     ld_cap;
		logic     ld_wr;
		logic     clr_batch;
		logic     sum_rd;
		logic     acc_clr;
		logic     pt_rd;
		logic     div_go;
		logic     fix;
		logic     emit;
		logic     last_step;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic acc_busy;
	} dp_stat_t;

	function automatic int unsigned bits_for(input int unsigned v);
		return (v > 1) ? $clog2(v) : 1;
	endfunction

endpackage

// ----- hw/rtl/trmcov_div.sv -----
// serial floor divider: signed dividend by positive divisor, one bit a cycle
// has no dependency on trmcov_pkg
`timescale 1ns / 1ps
module trmcov_div #(
	parameter int W  = 64,
	parameter int NW = 11,
	localparam int CW = (W + 1 > 1) ? $clog2(W + 1) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [W-1:0]  dividend,
	input  logic        [NW-1:0] divisor,
	output logic signed [W-1:0]  quot,
	output logic        [NW-1:0] rem,
	output logic                 done
);
	logic [W-1:0]  mq_q;
	logic [NW-1:0] rem_q;
	logic [NW:0]   rem_n;
	logic          ge;
	logic          neg_q;
	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	assign rem_n = {rem_q, mq_q[W-1]};
	assign ge    = rem_n >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				neg_q <= dividend[W-1];
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

	// negative dividend runs on ~a = -a-1, floor result folds back below
	always_ff @(posedge clk) begin
		if (start) begin
			mq_q  <= dividend[W-1] ? ~dividend : dividend;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? NW'(rem_n - {1'b0, divisor}) : NW'(rem_n);
			mq_q  <= {mq_q[W-2:0], ge};
		end
	end

	assign quot = neg_q ? ~mq_q : mq_q;
	assign rem  = neg_q ? NW'(divisor - NW'(1) - rem_q) : rem_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/trmcov_ctrl.sv -----
// controller: load sequencing, per-step compute sequencing, config registers
// depends on trmcov_pkg
`timescale 1ns / 1ps
module trmcov_ctrl #(
	parameter int unsigned MAX_SAMPLES = trmcov_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned MAX_STEPS   = trmcov_pkg::MAX_STEPS_DEF,
	localparam int CNT_W  = trmcov_pkg::bits_for(MAX_SAMPLES + 1),
	localparam int SIDX_W = trmcov_pkg::bits_for(MAX_SAMPLES),
	localparam int TIDX_W = trmcov_pkg::bits_for(MAX_STEPS),
	localparam int TCNT_W = trmcov_pkg::bits_for(MAX_STEPS + 1),
	localparam int AW     = trmcov_pkg::bits_for(MAX_SAMPLES * MAX_STEPS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [trmcov_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  trmcov_pkg::dp_stat_t                  stat,
	output trmcov_pkg::dp_cmd_t                   cmd,
	output logic [CNT_W-1:0]                      ns,
	output logic [TIDX_W-1:0]                     sum_addr,
	output logic [AW-1:0]                         pt_waddr,
	output logic [AW-1:0]                         pt_raddr,
	output logic [TIDX_W-1:0]                     t_idx
);
	import trmcov_pkg::*;

	state_t                state_q, state_d;
	logic [CFG_DATA_W-1:0] samp_cnt_q;
	logic [STEPC_W-1:0]    step_cnt_q;
	logic [TCNT_W-1:0]     nt;
	logic [TIDX_W-1:0]     step_q, t_q;
	logic [SIDX_W-1:0]     samp_q;
	logic [AW-1:0]         waddr_q, raddr_q;
	logic [CNT_W-1:0]      i_q;
	logic                  go_q, go_d;
	logic                  cfg_acc, last_pt_step, last_samp, last_t, last_i;

	// effective counts: zero reads as one, overrange clamps
	always_comb begin
		if (samp_cnt_q == '0)
			ns = CNT_W'(1);
		else if (32'(samp_cnt_q) > MAX_SAMPLES)
			ns = CNT_W'(MAX_SAMPLES);
		else
			ns = CNT_W'(samp_cnt_q);
		if (step_cnt_q == '0)
			nt = TCNT_W'(1);
		else if (32'(step_cnt_q) > MAX_STEPS)
			nt = TCNT_W'(MAX_STEPS);
		else
			nt = TCNT_W'(step_cnt_q);
	end

	assign busy         = state_q != ST_IDLE;
	assign cfg_ready    = (state_q == ST_IDLE) && !start;
	assign cfg_acc      = cfg_valid && cfg_ready;
	assign last_pt_step = (TCNT_W'(step_q) + TCNT_W'(1)) == nt;
	assign last_samp    = (CNT_W'(samp_q) + CNT_W'(1)) == ns;
	assign last_t       = (TCNT_W'(t_q) + TCNT_W'(1)) == nt;
	assign last_i       = (i_q + CNT_W'(1)) == ns;
	assign sum_addr     = (state_q == ST_RDSUM) ? t_q : step_q;
	assign pt_waddr     = waddr_q;
	assign pt_raddr     = raddr_q;
	assign t_idx        = t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_cnt_q <= SAMPLE_COUNT_RST;
			step_cnt_q <= STEP_COUNT_RST;
			step_q     <= '0;
			samp_q     <= '0;
			waddr_q    <= '0;
			t_q        <= '0;
			i_q        <= '0;
			raddr_q    <= '0;
			go_q       <= 1'b0;
		end else begin
			go_q <= go_d;
			if (cfg_acc) begin
				if (cfg_index == REG_SAMPLE_COUNT)
					samp_cnt_q <= cfg_data;
				else
					step_cnt_q <= cfg_data[STEPC_W-1:0];
				step_q  <= '0;
				samp_q  <= '0;
				waddr_q <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (last_pt_step) begin
						step_q <= '0;
						if (last_samp) begin
							samp_q  <= '0;
							waddr_q <= '0;
							t_q     <= '0;
						end else begin
							samp_q  <= samp_q + SIDX_W'(1);
							waddr_q <= waddr_q + AW'(1);
						end
					end else begin
						step_q  <= step_q + TIDX_W'(1);
						waddr_q <= waddr_q + AW'(1);
					end
				end
				ST_DMH: begin
					if (stat.div_done) begin
						i_q     <= '0;
						raddr_q <= AW'(t_q);
					end
				end
				ST_ACC: begin
					i_q     <= i_q + CNT_W'(1);
					raddr_q <= raddr_q + AW'(nt);
				end
				ST_EMIT: begin
					t_q <= t_q + TIDX_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_MX;
		case (state_q)
			ST_IDLE: begin
				if (cfg_acc)
					cmd.clr_batch = 1'b1;
				if (start) begin
					cmd.ld_cap = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.ld_wr = 1'b1;
				state_d   = (last_pt_step && last_samp) ? ST_RDSUM : ST_IDLE;
			end
			ST_RDSUM: begin
				cmd.sum_rd  = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = ST_DMX;
			end
			ST_DMX: begin
				cmd.div_sel = DIV_MX;
				if (stat.div_done)
					state_d = ST_DMY;
			end
			ST_DMY: begin
				cmd.div_sel = DIV_MY;
				if (stat.div_done)
					state_d = ST_DMH;
			end
			ST_DMH: begin
				cmd.div_sel = DIV_MH;
				if (stat.div_done)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.pt_rd = 1'b1;
				if (last_i)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.acc_busy)
					state_d = ST_DVXX;
			end
			ST_DVXX: begin
				cmd.div_sel = DIV_VXX;
				if (stat.div_done)
					state_d = ST_DVYY;
			end
			ST_DVYY: begin
				cmd.div_sel = DIV_VYY;
				if (stat.div_done)
					state_d = ST_DCXY;
			end
			ST_DCXY: begin
				cmd.div_sel = DIV_CXY;
				if (stat.div_done)
					state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit      = 1'b1;
				cmd.last_step = last_t;
				if (last_t) begin
					cmd.clr_batch = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_RDSUM;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.div_go = go_q;
		go_d = (state_d inside {ST_DMX, ST_DMY, ST_DMH, ST_DVXX, ST_DVYY, ST_DCXY})
			&& (state_d != state_q);
	end

endmodule

// ----- hw/rtl/trmcov_dp.sv -----
// datapath: point store, per-step sums, deviation products, divider, result regs
// depends on trmcov_pkg and trmcov_div
`timescale 1ns / 1ps
module trmcov_dp #(
	parameter int unsigned MAX_SAMPLES = trmcov_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned MAX_STEPS   = trmcov_pkg::MAX_STEPS_DEF,
	localparam int CNT_W  = trmcov_pkg::bits_for(MAX_SAMPLES + 1),
	localparam int TIDX_W = trmcov_pkg::bits_for(MAX_STEPS),
	localparam int AW     = trmcov_pkg::bits_for(MAX_SAMPLES * MAX_STEPS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  trmcov_pkg::dp_cmd_t                   cmd,
	output trmcov_pkg::dp_stat_t                  stat,
	input  logic signed [trmcov_pkg::POS_W-1:0]   pos_x,
	input  logic signed [trmcov_pkg::POS_W-1:0]   pos_y,
	input  logic signed [trmcov_pkg::HEAD_W-1:0]  heading,
	input  logic [CNT_W-1:0]                      ns,
	input  logic [TIDX_W-1:0]                     sum_addr,
	input  logic [AW-1:0]                         pt_waddr,
	input  logic [AW-1:0]                         pt_raddr,
	input  logic [TIDX_W-1:0]                     t_idx,
	output logic                                  res_strobe,
	output logic [trmcov_pkg::TS_W-1:0]           time_step,
	output logic signed [trmcov_pkg::POS_W-1:0]   mean_x,
	output logic signed [trmcov_pkg::POS_W-1:0]   mean_y,
	output logic signed [trmcov_pkg::HEAD_W-1:0]  mean_heading,
	output logic [trmcov_pkg::VAR_W-1:0]          var_xx,
	output logic signed [trmcov_pkg::COV_W-1:0]   cov_xy,
	output logic [trmcov_pkg::VAR_W-1:0]          var_yy,
	output logic                                  final_res
);
	import trmcov_pkg::*;

	localparam int SUMP_W = POS_W + CNT_W;
	localparam int SUMH_W = HEAD_W + CNT_W;
	localparam int DX_W   = POS_W + 1;
	localparam int PROD_W = 2 * DX_W;
	localparam int ACC_W  = PROD_W + CNT_W;
	localparam int P2_W   = 2 * CNT_W;
	localparam int DEPTH  = MAX_SAMPLES * MAX_STEPS;

	logic [2*POS_W-1:0]       pmem [DEPTH];
	logic signed [SUMP_W-1:0] sumx_mem [MAX_STEPS];
	logic signed [SUMP_W-1:0] sumy_mem [MAX_STEPS];
	logic signed [SUMH_W-1:0] sumh_mem [MAX_STEPS];
	logic [MAX_STEPS-1:0]     valid_q;

	logic signed [POS_W-1:0]  in_x_s1, in_y_s1;
	logic signed [HEAD_W-1:0] in_h_s1;
	logic signed [SUMP_W-1:0] sx_s1, sy_s1;
	logic signed [SUMH_W-1:0] sh_s1;

	logic signed [POS_W-1:0]  pt_x_s1, pt_y_s1;
	logic signed [DX_W-1:0]   dx_s2, dy_s2;
	logic signed [PROD_W-1:0] pxx_s3, pyy_s3, pxy_s3;
	logic                     v1_q, v2_q, v3_q;
	logic signed [ACC_W-1:0]  acc_xx_q, acc_yy_q, acc_xy_q;

	logic signed [ACC_W-1:0]  div_a, div_q;
	logic [CNT_W-1:0]         div_r;
	logic                     div_done;

	logic signed [POS_W-1:0]  mx_q, my_q;
	logic signed [HEAD_W-1:0] mh_q;
	logic [CNT_W-1:0]         rx_q, ry_q, rxx_q, ryy_q, rxy_q;
	logic signed [ACC_W-1:0]  qxx_q, qyy_q, qxy_q;
	logic [P2_W-1:0]          snxx_s1, snyy_s1, snxy_s1, rrxx_s1, rryy_s1, rrxy_s1;
	logic signed [ACC_W-1:0]  vxx_d, vyy_d, cxy_d;

	logic                     strobe_q, final_q;
	logic [TS_W-1:0]          ts_q;
	logic [VAR_W-1:0]         vxx_q, vyy_q;
	logic signed [COV_W-1:0]  cxy_q;

	// point store, no reset: only entries of the running batch are read
	always_ff @(posedge clk) begin
		if (cmd.ld_wr)
			pmem[pt_waddr] <= {in_x_s1, in_y_s1};
	end

	always_ff @(posedge clk) begin
		if (cmd.pt_rd)
			{pt_x_s1, pt_y_s1} <= pmem[pt_raddr];
	end

	// per-step sums, entries not yet valid in this batch read as zero
	always_ff @(posedge clk) begin
		if (cmd.ld_wr) begin
			sumx_mem[sum_addr] <= sx_s1 + SUMP_W'(in_x_s1);
			sumy_mem[sum_addr] <= sy_s1 + SUMP_W'(in_y_s1);
			sumh_mem[sum_addr] <= sh_s1 + SUMH_W'(in_h_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_cap || cmd.sum_rd) begin
			sx_s1 <= valid_q[sum_addr] ? sumx_mem[sum_addr] : '0;
			sy_s1 <= valid_q[sum_addr] ? sumy_mem[sum_addr] : '0;
			sh_s1 <= valid_q[sum_addr] ? sumh_mem[sum_addr] : '0;
		end
		if (cmd.ld_cap) begin
			in_x_s1 <= pos_x;
			in_y_s1 <= pos_y;
			in_h_s1 <= heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.clr_batch)
				valid_q <= '0;
			else if (cmd.ld_wr)
				valid_q[sum_addr] <= 1'b1;
			v1_q     <= cmd.pt_rd;
			v2_q     <= v1_q;
			v3_q     <= v2_q;
			strobe_q <= cmd.emit;
		end
	end

	// deviation products and sums over the candidates of one step
	always_ff @(posedge clk) begin
		dx_s2  <= DX_W'(pt_x_s1) - DX_W'(mx_q);
		dy_s2  <= DX_W'(pt_y_s1) - DX_W'(my_q);
		pxx_s3 <= dx_s2 * dx_s2;
		pyy_s3 <= dy_s2 * dy_s2;
		pxy_s3 <= dx_s2 * dy_s2;
		if (cmd.acc_clr) begin
			acc_xx_q <= '0;
			acc_yy_q <= '0;
			acc_xy_q <= '0;
		end else if (v3_q) begin
			acc_xx_q <= acc_xx_q + ACC_W'(pxx_s3);
			acc_yy_q <= acc_yy_q + ACC_W'(pyy_s3);
			acc_xy_q <= acc_xy_q + ACC_W'(pxy_s3);
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_MX:  div_a = ACC_W'(sx_s1);
			DIV_MY:  div_a = ACC_W'(sy_s1);
			DIV_MH:  div_a = ACC_W'(sh_s1);
			DIV_VXX: div_a = acc_xx_q;
			DIV_VYY: div_a = acc_yy_q;
			DIV_CXY: div_a = acc_xy_q;
			default: div_a = '0;
		endcase
	end

	trmcov_div #(
		.W  (ACC_W),
		.NW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (div_a),
		.divisor  (ns),
		.quot     (div_q),
		.rem      (div_r),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				DIV_MX: begin
					mx_q <= POS_W'(div_q);
					rx_q <= div_r;
				end
				DIV_MY: begin
					my_q <= POS_W'(div_q);
					ry_q <= div_r;
				end
				DIV_MH:  mh_q <= HEAD_W'(div_q);
				DIV_VXX: begin
					qxx_q <= div_q;
					rxx_q <= div_r;
				end
				DIV_VYY: begin
					qyy_q <= div_q;
					ryy_q <= div_r;
				end
				DIV_CXY: begin
					qxy_q <= div_q;
					rxy_q <= div_r;
				end
				default: begin
				end
			endcase
		end
	end

	// exact floor of (n*D - r^2) / n^2: step q down when s*n < r^2
	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			snxx_s1 <= P2_W'(rxx_q) * P2_W'(ns);
			snyy_s1 <= P2_W'(ryy_q) * P2_W'(ns);
			snxy_s1 <= P2_W'(rxy_q) * P2_W'(ns);
			rrxx_s1 <= P2_W'(rx_q) * P2_W'(rx_q);
			rryy_s1 <= P2_W'(ry_q) * P2_W'(ry_q);
			rrxy_s1 <= P2_W'(rx_q) * P2_W'(ry_q);
		end
	end

	assign vxx_d = (snxx_s1 >= rrxx_s1) ? qxx_q : qxx_q - ACC_W'(1);
	assign vyy_d = (snyy_s1 >= rryy_s1) ? qyy_q : qyy_q - ACC_W'(1);
	assign cxy_d = (snxy_s1 >= rrxy_s1) ? qxy_q : qxy_q - ACC_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ts_q    <= TS_W'(t_idx);
			vxx_q   <= VAR_W'(vxx_d);
			vyy_q   <= VAR_W'(vyy_d);
			cxy_q   <= COV_W'(cxy_d);
			final_q <= cmd.last_step;
		end
	end

	assign stat.div_done = div_done;
	assign stat.acc_busy = v1_q || v2_q || v3_q;

	// means stay put until the next step's divisions, past the strobe cycle
	assign res_strobe   = strobe_q;
	assign time_step    = ts_q;
	assign mean_x       = mx_q;
	assign mean_y       = my_q;
	assign mean_heading = mh_q;
	assign var_xx       = vxx_q;
	assign cov_xy       = cxy_q;
	assign var_yy       = vyy_q;
	assign final_res    = final_q;

endmodule

// ----- hw/rtl/trajectory_mean_xy_covariance_core.sv -----
// top level of the trajectory mean and x/y covariance core
// depends on trmcov_pkg, trmcov_ctrl, trmcov_dp (and trmcov_div below it)
//
// usage
//   points (pos_x, pos_y, heading) come in candidate by candidate, step by step
//   within a candidate; a point transfers at a clock edge with start high and
//   busy low. each point is captured, with the step's running sums read, while
//   idle, then written to the sums and the point store in the load state (busy high).
//   after the last point of the batch the core computes each time step in
//   turn and presents one result on the result ports for one cycle, marked by
//   res_strobe; final_res flags the last step. per step it runs six serial
//   divisions in one shared divider (mean x, y, heading, then xx, yy, xy sums),
//   one pass over the batch's points through the point store read port,
//   a drain of the product pipeline and a fix-up of the variances before the
//   result is emitted; ACC_W, the divider width, is 61 at the default sizes.
//   the receiver cannot stall; results are simply shown once.
//   config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken only
//   while idle and restart the batch. reset clears the control state and sets
//   sample_count to 1024 and step_count to 64; no clearing pass is needed.
`timescale 1ns / 1ps
module trajectory_mean_xy_covariance_core #(
	parameter int unsigned MAX_SAMPLES = trmcov_pkg::MAX_SAMPLES_DEF,
	parameter int unsigned MAX_STEPS   = trmcov_pkg::MAX_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [trmcov_pkg::POS_W-1:0]   pos_x,
	input  logic signed [trmcov_pkg::POS_W-1:0]   pos_y,
	input  logic signed [trmcov_pkg::HEAD_W-1:0]  heading,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [trmcov_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                  res_strobe,
	output logic [trmcov_pkg::TS_W-1:0]           time_step,
	output logic signed [trmcov_pkg::POS_W-1:0]   mean_x,
	output logic signed [trmcov_pkg::POS_W-1:0]   mean_y,
	output logic signed [trmcov_pkg::HEAD_W-1:0]  mean_heading,
	output logic [trmcov_pkg::VAR_W-1:0]          var_xx,
	output logic signed [trmcov_pkg::COV_W-1:0]   cov_xy,
	output logic [trmcov_pkg::VAR_W-1:0]          var_yy,
	output logic                                  final_res
);
	import trmcov_pkg::*;

	localparam int CNT_W  = bits_for(MAX_SAMPLES + 1);
	localparam int TIDX_W = bits_for(MAX_STEPS);
	localparam int AW     = bits_for(MAX_SAMPLES * MAX_STEPS);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CNT_W-1:0]  ns;
	logic [TIDX_W-1:0] sum_addr, t_idx;
	logic [AW-1:0]     pt_waddr, pt_raddr;

	// sequencing of load and compute, config registers, effective counts
	trmcov_ctrl #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_STEPS   (MAX_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd),
		.ns        (ns),
		.sum_addr  (sum_addr),
		.pt_waddr  (pt_waddr),
		.pt_raddr  (pt_raddr),
		.t_idx     (t_idx)
	);

	// storage, arithmetic and result registers
	trmcov_dp #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.MAX_STEPS   (MAX_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.ns           (ns),
		.sum_addr     (sum_addr),
		.pt_waddr     (pt_waddr),
		.pt_raddr     (pt_raddr),
		.t_idx        (t_idx),
		.res_strobe   (res_strobe),
		.time_step    (time_step),
		.mean_x       (mean_x),
		.mean_y       (mean_y),
		.mean_heading (mean_heading),
		.var_xx       (var_xx),
		.cov_xy       (cov_xy),
		.var_yy       (var_yy),
		.final_res    (final_res)
	);

endmodule

// ----- hw/rtl/trmcov_chk.sv -----
// port-level checks for the trajectory mean and x/y covariance core
// bound to trajectory_mean_xy_covariance_core below
`timescale 1ns / 1ps
module trmcov_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic res_strobe,
	input logic final_res
);

	// an accepted point always occupies the write cycle
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("no write cycle after point transfer");

	// results of consecutive steps are spread by the divisions
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |=> !res_strobe)
		else $error("back to back result strobes");

	// more steps follow a non-final result, so the core stays busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !final_res |-> busy)
		else $error("idle after non-final result");

	// config transfer only when nothing else moves
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy && !start)
		else $error("config transfer while busy or loading");

endmodule

bind trajectory_mean_xy_covariance_core trmcov_chk u_trmcov_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.res_strobe (res_strobe),
	.final_res  (final_res)
);

// ----- verif/trajectory_mean_xy_covariance_core_tb.sv -----
// self-checking testbench for trajectory_mean_xy_covariance_core
// depends on trmcov_pkg and the core rtl; predicts per-step means and covariances
`timescale 1ns / 1ps
module trajectory_mean_xy_covariance_core_tb;
	import trmcov_pkg::*;

	localparam int NS_MAX   = 1024;
	localparam int NT_MAX   = 64;
	localparam int SETTLE   = 24;   // settling wait after all expected results are in

	// one per-step statistics record as the core presents it
	typedef struct {
		logic [TS_W-1:0]          ts;
		logic signed [POS_W-1:0]  mx;
		logic signed [POS_W-1:0]  my;
		logic signed [HEAD_W-1:0] mh;
		logic [VAR_W-1:0]         vxx;
		logic signed [COV_W-1:0]  cxy;
		logic [VAR_W-1:0]         vyy;
		logic                     fin;
	} step_stats_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [HEAD_W-1:0] heading;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic                     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     res_strobe;
	logic [TS_W-1:0]          time_step;
	logic signed [POS_W-1:0]  mean_x;
	logic signed [POS_W-1:0]  mean_y;
	logic signed [HEAD_W-1:0] mean_heading;
	logic [VAR_W-1:0]         var_xx;
	logic signed [COV_W-1:0]  cov_xy;
	logic [VAR_W-1:0]         var_yy;
	logic                     final_res;

	trajectory_mean_xy_covariance_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .res_strobe(res_strobe), .time_step(time_step),
		.mean_x(mean_x), .mean_y(mean_y), .mean_heading(mean_heading),
		.var_xx(var_xx), .cov_xy(cov_xy), .var_yy(var_yy), .final_res(final_res)
	);

	always #4 clk = ~clk;

	// predictor state: shadow registers, kept points, per-step running sums
	logic [CFG_DATA_W-1:0]    shadow_samples;
	logic [STEPC_W-1:0]       shadow_steps;
	logic signed [POS_W-1:0]  kept_x [0:NS_MAX*NT_MAX-1];
	logic signed [POS_W-1:0]  kept_y [0:NS_MAX*NT_MAX-1];
	longint                   run_sum_x [0:NT_MAX-1];
	longint                   run_sum_y [0:NT_MAX-1];
	longint                   run_sum_h [0:NT_MAX-1];
	int unsigned              cand_idx;
	int unsigned              step_idx;

	step_stats_t pending_stats [$];
	int          mismatch_count = 0;
	int          points_sent    = 0;
	int          stats_seen     = 0;
	int          batches_done   = 0;
	bit          gaps_on        = 1'b1;

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic int unsigned live_samples();
		if (shadow_samples == 0) return 1;
		if (shadow_samples > NS_MAX) return NS_MAX;
		return 32'(shadow_samples);
	endfunction

	function automatic int unsigned live_steps();
		if (shadow_steps == 0) return 1;
		if (shadow_steps > NT_MAX) return NT_MAX;
		return 32'(shadow_steps);
	endfunction

	function automatic void clear_batch();
		for (int t = 0; t < NT_MAX; t++) begin
			run_sum_x[t] = 0;
			run_sum_y[t] = 0;
			run_sum_h[t] = 0;
		end
		cand_idx = 0;
		step_idx = 0;
	endfunction

	// statistics of one time step over the whole batch
	function automatic step_stats_t batch_step_stats(input int unsigned t,
			input int unsigned ns, input int unsigned nt);
		step_stats_t r;
		longint n, mx, my, mh, rx, ry, dx, dy, dxy, qc, sc;
		longint unsigned dxx, dyy, un, q, s;
		n   = longint'(ns);
		un  = longint'(ns);
		mx  = floor_div(run_sum_x[t], n);
		my  = floor_div(run_sum_y[t], n);
		mh  = floor_div(run_sum_h[t], n);
		rx  = run_sum_x[t] - mx * n;
		ry  = run_sum_y[t] - my * n;
		dxx = 0;
		dyy = 0;
		dxy = 0;
		for (int i = 0; i < ns; i++) begin
			dx  = longint'(kept_x[i*NT_MAX+t]) - mx;
			dy  = longint'(kept_y[i*NT_MAX+t]) - my;
			dxx = dxx + longint'(dx * dx);
			dyy = dyy + longint'(dy * dy);
			dxy = dxy + dx * dy;
		end
		// floor of the exact (n*D - r^2) / n^2
		q = dxx / un;
		s = dxx % un;
		r.vxx = VAR_W'((s * un >= longint'(rx * rx)) ? q : q - 1);
		q = dyy / un;
		s = dyy % un;
		r.vyy = VAR_W'((s * un >= longint'(ry * ry)) ? q : q - 1);
		qc = floor_div(dxy, n);
		sc = dxy - qc * n;
		r.cxy = COV_W'((sc * n >= rx * ry) ? qc : qc - 1);
		r.ts  = TS_W'(t);
		r.mx  = POS_W'(mx);
		r.my  = POS_W'(my);
		r.mh  = HEAD_W'(mh);
		r.fin = (t + 1 == nt);
		return r;
	endfunction

	function automatic void predict_point(input logic signed [POS_W-1:0] x,
			input logic signed [POS_W-1:0] y, input logic signed [HEAD_W-1:0] h);
		int unsigned ns, nt;
		ns = live_samples();
		nt = live_steps();
		if (cand_idx >= ns || step_idx >= nt)
			clear_batch();
		kept_x[cand_idx*NT_MAX+step_idx] = x;
		kept_y[cand_idx*NT_MAX+step_idx] = y;
		run_sum_x[step_idx] += x;
		run_sum_y[step_idx] += y;
		run_sum_h[step_idx] += h;
		step_idx++;
		if (step_idx < nt) return;
		step_idx = 0;
		cand_idx++;
		if (cand_idx < ns) return;
		for (int t = 0; t < nt; t++)
			pending_stats = {pending_stats, batch_step_stats(t, ns, nt)};
		batches_done++;
		clear_batch();
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 30)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// checker: every strobed result against the oldest expected record
	always @(posedge clk) begin
		step_stats_t e;
		if (arst_n && res_strobe) begin
			stats_seen++;
			if (pending_stats.size() == 0) begin
				report_mismatch("unexpected result, step", 64'(time_step), 64'd0);
			end else begin
				e = pending_stats.pop_front();
				if (time_step !== e.ts)
					report_mismatch("time_step", 64'(time_step), 64'(e.ts));
				if (mean_x !== e.mx) report_mismatch("mean_x", 64'(mean_x), 64'(e.mx));
				if (mean_y !== e.my) report_mismatch("mean_y", 64'(mean_y), 64'(e.my));
				if (mean_heading !== e.mh)
					report_mismatch("mean_heading", 64'(mean_heading), 64'(e.mh));
				if (var_xx !== e.vxx) report_mismatch("var_xx", 64'(var_xx), 64'(e.vxx));
				if (cov_xy !== e.cxy) report_mismatch("cov_xy", 64'(cov_xy), 64'(e.cxy));
				if (var_yy !== e.vyy) report_mismatch("var_yy", 64'(var_yy), 64'(e.vyy));
				if (final_res !== e.fin)
					report_mismatch("final_res", 64'(final_res), 64'(e.fin));
			end
		end
	end

	// one point transfer; start stays high afterwards so back-to-back points
	// need no extra nonblocking write in the same step
	task automatic send_point(input logic signed [POS_W-1:0] x,
			input logic signed [POS_W-1:0] y, input logic signed [HEAD_W-1:0] h);
		if (gaps_on) begin
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start   <= 1'b1;
		pos_x   <= x;
		pos_y   <= y;
		heading <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_point(x, y, h);
		points_sent++;
	endtask

	// drop start and let everything expected arrive, then let the core settle
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_SAMPLE_COUNT)
			shadow_samples = val;
		else
			shadow_steps = val[STEPC_W-1:0];
		clear_batch();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_shape(input int unsigned ns, input int unsigned nt);
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(ns));
		write_reg(REG_STEP_COUNT, CFG_DATA_W'(nt));
	endtask

	// positions: full range, edges, or a tight cluster for small spreads
	function automatic logic signed [POS_W-1:0] pick_pos();
		case ($urandom_range(3))
			0: return POS_W'($urandom);
			1: case ($urandom_range(3))
				0: return {1'b0, {(POS_W-1){1'b1}}};
				1: return {1'b1, {(POS_W-1){1'b0}}};
				2: return '0;
				default: return '1;
			endcase
			default: return POS_W'(int'($urandom_range(1023)) - 512);
		endcase
	endfunction

	function automatic logic signed [HEAD_W-1:0] pick_heading();
		case ($urandom_range(2))
			0: return HEAD_W'($urandom);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return HEAD_W'(int'($urandom_range(255)) - 128);
		endcase
	endfunction

	task automatic send_random_points(input int count);
		for (int k = 0; k < count; k++)
			send_point(pick_pos(), pick_pos(), pick_heading());
	endtask

	// extreme values in both directions, including the widest spread
	task automatic test_field_extremes();
		set_shape(2, 2);
		send_point(24'sh7fffff, 24'sh7fffff, 16'sh7fff);
		send_point(24'sh800000, 24'sh800000, 16'sh8000);
		send_point(24'sh800000, 24'sh7fffff, 16'sh8000);
		send_point(24'sh7fffff, 24'sh800000, 16'sh7fff);
		send_point(24'sh7fffff, 24'sh7fffff, 16'sh7fff);
		send_point(24'sh7fffff, 24'sh7fffff, 16'sh7fff);
		send_point(24'sh800000, 24'sh800000, 16'sh8000);
		send_point(24'sh800000, 24'sh800000, 16'sh8000);
		wait_quiet();
		// odd count so floor rounding of negative means shows
		set_shape(3, 1);
		send_point(-24'sd1, 24'sd1, -16'sd1);
		send_point(24'sd0, -24'sd2, 16'sd0);
		send_point(24'sd0, 24'sd0, 16'sd0);
		wait_quiet();
	endtask

	// zero counts act as one, oversize step count acts as the maximum
	task automatic test_count_limits();
		set_shape(0, 0);
		send_random_points(1);
		wait_quiet();
		set_shape(1, 64);
		send_random_points(64);
		wait_quiet();
		set_shape(0, 127);
		send_random_points(64);
		wait_quiet();
	endtask

	// many candidates over a single step
	task automatic test_wide_batch();
		set_shape(160, 1);
		send_random_points(160);
		wait_quiet();
	endtask

	// a register write part way through a batch throws the partial batch away
	task automatic test_restart_mid_batch();
		set_shape(3, 2);
		send_random_points(3);
		wait_quiet();
		write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(2));
		send_random_points(4);
		wait_quiet();
	endtask

	task automatic test_random_batches(input int target);
		int unsigned ns, nt;
		int stop_at;
		stop_at = points_sent + target;
		gaps_on = 1'b0;
		while (points_sent < stop_at) begin
			// first stretch runs with no sender gaps at all
			if (points_sent > stop_at - target + 120) gaps_on = 1'b1;
			ns = $urandom_range(6, 1);
			nt = $urandom_range(6, 1);
			set_shape(ns, nt);
			repeat ($urandom_range(3, 1)) begin
				if ($urandom_range(9) == 0) begin
					// broken batch, then a fresh shape restarts it
					send_random_points($urandom_range(ns * nt - 1 + 1, 1) - 1);
					wait_quiet();
					set_shape(ns, nt);
				end
				send_random_points(ns * nt);
				// sometimes hold the next batch until all results are in
				if ($urandom_range(3) == 0) wait_quiet();
			end
			wait_quiet();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     <= 1'b0;
		pos_x     <= '0;
		pos_y     <= '0;
		heading   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SAMPLE_COUNT;
		cfg_data  <= '0;
		shadow_samples = SAMPLE_COUNT_RST;
		shadow_steps   = STEP_COUNT_RST;
		clear_batch();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_restart_mid_batch();
		test_count_limits();
		test_wide_batch();
		test_random_batches(160);

		wait_quiet();
		$display("covered %0d points in %0d batches, %0d step results checked",
			points_sent, batches_done, stats_seen);
		$display("shapes up to 160 candidates and 64 steps, zero and oversize counts");
		if (mismatch_count == 0 && pending_stats.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
